[design/asba_pkg.sv]
// Package for the ADC scaling block averager: widths, register map, reset values and constants.
package asba_pkg;

   // Number of items summed into one average.
   localparam int WINDOW    = 10;

   localparam int NUM_CH    = 4;
   localparam int SAMPLE_W  = 12;
   localparam int GAIN_W    = 24;
   localparam int OFFSET_W  = 32;
   localparam int PROD_W    = GAIN_W + SAMPLE_W;
   localparam int TERM_W    = PROD_W + 1;
   localparam int ACC_W     = 42;
   localparam int COUNT_W   = 4;
   localparam int FRAC_W    = 16;
   localparam int MEAN_W    = ACC_W - FRAC_W;
   localparam int AVG_W     = 21;

   // Floor division by WINDOW through a reciprocal. The shifted sum is biased by
   // WINDOW * 2^(AVG_W-1) so the dividend is never negative and stays below 2^DIV_IN_W.
   localparam int DIV_IN_W    = 25;
   localparam int DIV_SHIFT   = DIV_IN_W + 4;
   localparam int DIV_MULT_W  = DIV_SHIFT + 1;
   localparam int DIV_PROD_W  = DIV_IN_W + DIV_MULT_W;
   localparam longint DIV_MULT_L = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(DIV_MULT_L);
   localparam logic [MEAN_W-1:0] MEAN_BIAS = MEAN_W'(longint'(WINDOW) << (AVG_W - 1));
   localparam logic [AVG_W-1:0] AVG_BIAS = AVG_W'(longint'(1) << (AVG_W - 1));

   // Channel lanes.
   localparam int CH_CURRENT_OUT = 0;
   localparam int CH_VOLTAGE_OUT = 1;
   localparam int CH_CURRENT_IN  = 2;
   localparam int CH_VOLTAGE_IN  = 3;

   // Configuration register map.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CURRENT_OUT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VOLTAGE_OUT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_CURRENT_IN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_VOLTAGE_IN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CURRENT_OUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_CURRENT_IN  = 3'd5;

   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [GAIN_W-1:0]     gain_type;
   typedef logic [OFFSET_W-1:0]   offset_type;
   typedef logic [TERM_W-1:0]     term_type;
   typedef logic [ACC_W-1:0]      acc_type;
   typedef logic [MEAN_W-1:0]     mean_type;
   typedef logic [AVG_W-1:0]      avg_type;
   typedef logic [COUNT_W-1:0]    count_type;

   localparam gain_type   GAIN_CURRENT_OUT_RST   = 24'd620335;
   localparam gain_type   GAIN_VOLTAGE_OUT_RST   = 24'd486566;
   localparam gain_type   GAIN_CURRENT_IN_RST    = 24'd620335;
   localparam gain_type   GAIN_VOLTAGE_IN_RST    = 24'd997305;
   localparam offset_type OFFSET_CURRENT_OUT_RST = 32'd254259954;
   localparam offset_type OFFSET_CURRENT_IN_RST  = 32'd256230949;

   localparam count_type  LAST_COUNT = COUNT_W'(WINDOW - 1);

endpackage

[design/adc_scale_block_average.sv]
// Top level of the ADC scaling block averager: scaling, window sums and averages.
// A window's result reaches rsp_valid after its last item has passed the input register,
// the scaled term, the window mean and the result register. Throughput: one item per
// cycle when not stalled, set by the per-item stages; one result per WINDOW items.
// Reset clears all pipeline valid flags, the four sums and the item count, and restores
// the default gains and offsets.
module adc_scale_block_average (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  asba_pkg::sample_type              req_sample_current_out,
   input  asba_pkg::sample_type              req_sample_voltage_out,
   input  asba_pkg::sample_type              req_sample_current_in,
   input  asba_pkg::sample_type              req_sample_voltage_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output asba_pkg::avg_type                 rsp_avg_current_out,
   output asba_pkg::avg_type                 rsp_avg_voltage_out,
   output asba_pkg::avg_type                 rsp_avg_current_in,
   output asba_pkg::avg_type                 rsp_avg_voltage_in,
   input  logic                              csr_wen,
   input  logic [asba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [asba_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import asba_pkg::*;

   // Configuration registers, one gain per lane and an offset on each current lane.
   gain_type   gain_ff [NUM_CH];
   offset_type offset_current_out_ff;
   offset_type offset_current_in_ff;
   offset_type lane_offset [NUM_CH];

   // Stage 1: registered input samples.
   logic       smp_vld_ff;
   sample_type smp_ff [NUM_CH];
   sample_type smp_in [NUM_CH];

   // Stage 2: scaled Q16 term, gain * raw minus offset.
   logic       term_vld_ff;
   term_type   term_ff [NUM_CH];
   term_type   term_in [NUM_CH];

   // Window sums and the item count.
   acc_type    acc_ff [NUM_CH];
   acc_type    acc_in [NUM_CH];
   count_type  cnt_ff;

   // Stage 3: completed sum shifted down by 2^16 (floor), still to be divided by WINDOW.
   logic       mean_vld_ff;
   mean_type   mean_ff [NUM_CH];
   mean_type   mean_in [NUM_CH];

   // Stage 4: result register.
   logic       rsp_vld_ff;
   avg_type    avg_ff [NUM_CH];
   avg_type    avg_in [NUM_CH];

   // Flow control. Each stage moves when its successor is empty or moving, so a result
   // waiting on a stalled output does not block items that do not close a window.
   logic rsp_go;
   logic mean_free;
   logic win_done;
   logic acc_go;
   logic term_free;
   logic smp_free;

   always_comb begin
      rsp_go    = !rsp_vld_ff || !rsp_stall;
      mean_free = !mean_vld_ff || rsp_go;
      win_done  = (cnt_ff == LAST_COUNT);
      // An item that closes the window needs the mean stage free; any other item only
      // updates the sums.
      acc_go    = term_vld_ff && (!win_done || mean_free);
      term_free = !term_vld_ff || acc_go;
      smp_free  = !smp_vld_ff || term_free;
   end

   assign req_stall = !smp_free;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_avg_current_out = avg_ff[CH_CURRENT_OUT];
   assign rsp_avg_voltage_out = avg_ff[CH_VOLTAGE_OUT];
   assign rsp_avg_current_in  = avg_ff[CH_CURRENT_IN];
   assign rsp_avg_voltage_in  = avg_ff[CH_VOLTAGE_IN];

   // Per-lane datapath.
   always_comb begin
      logic [PROD_W-1:0]     prod;
      logic [MEAN_W-1:0]     biased;
      logic [DIV_IN_W-1:0]   dividend;
      logic [DIV_PROD_W-1:0] div_prod;
      acc_type               term_ext;

      smp_in[CH_CURRENT_OUT] = req_sample_current_out;
      smp_in[CH_VOLTAGE_OUT] = req_sample_voltage_out;
      smp_in[CH_CURRENT_IN]  = req_sample_current_in;
      smp_in[CH_VOLTAGE_IN]  = req_sample_voltage_in;

      // Voltage lanes carry no offset.
      lane_offset[CH_CURRENT_OUT] = offset_current_out_ff;
      lane_offset[CH_VOLTAGE_OUT] = '0;
      lane_offset[CH_CURRENT_IN]  = offset_current_in_ff;
      lane_offset[CH_VOLTAGE_IN]  = '0;

      for (int i = 0; i < NUM_CH; i++) begin
         // The term lies in [-2^32, 2^36), so two's complement in TERM_W bits is exact.
         prod       = PROD_W'(gain_ff[i]) * PROD_W'(smp_ff[i]);
         term_in[i] = TERM_W'(prod) - TERM_W'(lane_offset[i]);

         term_ext   = {{(ACC_W - TERM_W){term_ff[i][TERM_W-1]}}, term_ff[i]};
         acc_in[i]  = acc_ff[i] + term_ext;
         // Dropping the fraction bits of a two's complement sum is a floor by 2^16.
         mean_in[i] = acc_in[i][ACC_W-1:FRAC_W];

         // floor(x / WINDOW): bias to a non-negative dividend, multiply by the rounded-up
         // reciprocal, then remove the bias, which is 2^(AVG_W-1) after the division.
         biased     = mean_ff[i] + MEAN_BIAS;
         dividend   = biased[DIV_IN_W-1:0];
         div_prod   = DIV_PROD_W'(dividend) * DIV_PROD_W'(DIV_MULT);
         avg_in[i]  = div_prod[DIV_SHIFT +: AVG_W] - AVG_BIAS;
      end
   end

   // Configuration writes; indexes beyond the map are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[CH_CURRENT_OUT] <= GAIN_CURRENT_OUT_RST;
         gain_ff[CH_VOLTAGE_OUT] <= GAIN_VOLTAGE_OUT_RST;
         gain_ff[CH_CURRENT_IN]  <= GAIN_CURRENT_IN_RST;
         gain_ff[CH_VOLTAGE_IN]  <= GAIN_VOLTAGE_IN_RST;
         offset_current_out_ff   <= OFFSET_CURRENT_OUT_RST;
         offset_current_in_ff    <= OFFSET_CURRENT_IN_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GAIN_CURRENT_OUT:   gain_ff[CH_CURRENT_OUT] <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_VOLTAGE_OUT:   gain_ff[CH_VOLTAGE_OUT] <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_CURRENT_IN:    gain_ff[CH_CURRENT_IN]  <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_VOLTAGE_IN:    gain_ff[CH_VOLTAGE_IN]  <= csr_wdata[GAIN_W-1:0];
            CSR_OFFSET_CURRENT_OUT: offset_current_out_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_CURRENT_IN:  offset_current_in_ff    <= csr_wdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state: valid flags, sums and the item count.
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff  <= 1'b0;
         term_vld_ff <= 1'b0;
         mean_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         cnt_ff      <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         if (smp_free) begin
            smp_vld_ff <= req_valid;
         end
         if (term_free) begin
            term_vld_ff <= smp_vld_ff;
         end
         if (mean_free) begin
            mean_vld_ff <= acc_go && win_done;
         end
         if (rsp_go) begin
            rsp_vld_ff <= mean_vld_ff;
         end
         if (acc_go) begin
            // The window's last item hands its sum to the mean stage and starts a new one.
            if (win_done) begin
               cnt_ff <= '0;
               for (int i = 0; i < NUM_CH; i++) begin
                  acc_ff[i] <= '0;
               end
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
               for (int i = 0; i < NUM_CH; i++) begin
                  acc_ff[i] <= acc_in[i];
               end
            end
         end
      end
   end

   // Payload registers load on a transfer into their stage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CH; i++) begin
         if (smp_free && req_valid) begin
            smp_ff[i] <= smp_in[i];
         end
         if (term_free && smp_vld_ff) begin
            term_ff[i] <= term_in[i];
         end
         if (acc_go && win_done) begin
            mean_ff[i] <= mean_in[i];
         end
         if (rsp_go && mean_vld_ff) begin
            avg_ff[i] <= avg_in[i];
         end
      end
   end

   // The item count never runs past the window's last item.
   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_COUNT)
      else $error("item count beyond window");

   // Input stall is only raised while the input register holds an item.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> smp_vld_ff)
      else $error("input stalled with empty input register");

   // Closing a window always leaves a mean in the next cycle, count and lane 0 sum cleared.
   a_window_close: assert property (@(posedge clock) disable iff (reset)
      (acc_go && win_done) |=> (mean_vld_ff && cnt_ff == '0 && acc_ff[0] == '0))
      else $error("window close lost its mean");

   // Reset leaves no result pending and an empty window.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_vld_ff && !mean_vld_ff && cnt_ff == '0))
      else $error("state not cleared by reset");

endmodule
